FILE: hdl/plim_pkg.sv
// Shared types and constants for the stereo peak limiter.
package plim_pkg;

    localparam int FRAC_BITS  = 23;
    localparam int GAIN_W     = 24;
    localparam int DIV_STEPS  = 23;
    localparam int CNT_W      = 5;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0] GAIN_ONE    = 24'd8388608;
    localparam logic [GAIN_W-1:0] CEIL_MIN    = 24'd528482;
    localparam logic [GAIN_W-1:0] RST_CEILING = 24'd8103895;
    localparam logic [GAIN_W-1:0] RST_ATTACK  = 24'd1923500;
    localparam logic [GAIN_W-1:0] RST_RELEASE = 24'd2184;
    localparam logic              RST_STEREO  = 1'b1;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_CEILING = 2'd0;
    localparam cfg_idx_t REG_ATTACK  = 2'd1;
    localparam cfg_idx_t REG_RELEASE = 2'd2;
    localparam cfg_idx_t REG_STEREO  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PEAK,
        ST_DIV,
        ST_GMUL,
        ST_GUPD,
        ST_MULL,
        ST_CLIPL,
        ST_MULR,
        ST_CLIPR,
        ST_OUT
    } plim_state_t;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic peak_load;
        logic div_step;
        logic gain_mul;
        logic gain_upd;
        logic mul_left;
        logic clip_left;
        logic mul_right;
        logic clip_right;
        logic out_load;
    } plim_cmd_t;

    typedef struct packed {
        logic div_go;
        logic out_busy;
    } plim_stat_t;

endpackage

FILE: hdl/plim_regs.sv
// Configuration register file behind the APB-style port.
module plim_regs
    import plim_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [GAIN_W-1:0]     ceiling,
    output logic [GAIN_W-1:0]     attack,
    output logic [GAIN_W-1:0]     release_c,
    output logic                  stereo
);

    logic [GAIN_W-1:0] ceiling_reg;
    logic [GAIN_W-1:0] attack_reg;
    logic [GAIN_W-1:0] release_reg;
    logic              stereo_reg;
    logic              wr_en;
    cfg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg <= RST_CEILING;
            attack_reg  <= RST_ATTACK;
            release_reg <= RST_RELEASE;
            stereo_reg  <= RST_STEREO;
        end else if (wr_en) begin
            case (idx)
                REG_CEILING: ceiling_reg <= pwdata[GAIN_W-1:0];
                REG_ATTACK:  attack_reg  <= pwdata[GAIN_W-1:0];
                REG_RELEASE: release_reg <= pwdata[GAIN_W-1:0];
                REG_STEREO:  stereo_reg  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CEILING: prdata = CFG_DATA_W'(ceiling_reg);
            REG_ATTACK:  prdata = CFG_DATA_W'(attack_reg);
            REG_RELEASE: prdata = CFG_DATA_W'(release_reg);
            REG_STEREO:  prdata = CFG_DATA_W'(stereo_reg);
            default:     prdata = '0;
        endcase
    end

    assign ceiling   = ceiling_reg;
    assign attack    = attack_reg;
    assign release_c = release_reg;
    assign stereo    = stereo_reg;

endmodule

FILE: hdl/plim_ctrl.sv
// Sequencing state machine for the peak limiter.
module plim_ctrl
    import plim_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  plim_stat_t stat,
    output plim_cmd_t  cmd
);

    plim_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              div_last;

    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_PEAK;
            end
            ST_PEAK: begin
                cnt_next   = '0;
                state_next = stat.div_go ? ST_DIV : ST_GMUL;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last) state_next = ST_GMUL;
            end
            ST_GMUL:  state_next = ST_GUPD;
            ST_GUPD:  state_next = ST_MULL;
            ST_MULL:  state_next = ST_CLIPL;
            ST_CLIPL: state_next = ST_MULR;
            ST_MULR:  state_next = ST_CLIPR;
            ST_CLIPR: state_next = ST_OUT;
            ST_OUT: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.capture  = s_tvalid;
            end
            ST_PEAK:  cmd.peak_load  = 1'b1;
            ST_DIV:   cmd.div_step   = 1'b1;
            ST_GMUL:  cmd.gain_mul   = 1'b1;
            ST_GUPD:  cmd.gain_upd   = 1'b1;
            ST_MULL:  cmd.mul_left   = 1'b1;
            ST_CLIPL: cmd.clip_left  = 1'b1;
            ST_MULR:  cmd.mul_right  = 1'b1;
            ST_CLIPR: cmd.clip_right = 1'b1;
            ST_OUT:   cmd.out_load   = !stat.out_busy;
            default: begin
            end
        endcase
    end

endmodule

FILE: hdl/plim_dp.sv
// Datapath: peak detect, serial divider, shared multiplier, gain state and output register.
module plim_dp
    import plim_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  plim_cmd_t              cmd,
    output plim_stat_t             stat,
    input  logic [SAMPLE_BITS-1:0] in_left,
    input  logic [SAMPLE_BITS-1:0] in_right,
    input  logic [GAIN_W-1:0]      ceiling,
    input  logic [GAIN_W-1:0]      attack,
    input  logic [GAIN_W-1:0]      release_c,
    input  logic                   stereo,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [SAMPLE_BITS-1:0] out_left,
    output logic [SAMPLE_BITS-1:0] out_right,
    output logic [GAIN_W-1:0]      out_gain
);

    localparam int S  = SAMPLE_BITS;
    localparam int MW = (S > GAIN_W) ? S : GAIN_W;
    localparam int PW = MW + GAIN_W;
    localparam int CW = S + FRAC_BITS;
    localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

    // Captured frame and configuration snapshot.
    logic [S-1:0]         mag_l_reg, mag_r_reg, ceil_s_reg;
    logic                 neg_l_reg, neg_r_reg, stereo_reg;
    logic [FRAC_BITS-1:0] low_reg;
    logic [GAIN_W-1:0]    atk_reg, rel_reg;

    // Divider and gain state.
    logic [S-1:0]      peak_reg, rem_reg;
    logic [GAIN_W-1:0] needed_reg, gain_reg;
    logic              attack_reg;
    logic [PW-1:0]     prod_reg;
    logic [S-1:0]      res_l_reg, res_r_reg;

    logic [S-1:0]         out_left_reg, out_right_reg;
    logic [GAIN_W-1:0]    out_gain_reg;
    logic                 m_tvalid_reg;

    logic [GAIN_W-1:0] ceil_sat, atk_sat, rel_sat;
    logic [CW-1:0]     ceil_scaled;
    logic [S-1:0]      mag_l, mag_r, peak;
    logic              exceed;
    logic [S:0]        trial;
    logic              trial_ge;
    logic [S:0]        trial_diff;
    logic              go_attack;
    logic [MW-1:0]     mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic [PW-1:0]     prod_rnd;
    logic [GAIN_W-1:0] step_g;
    logic [S-1:0]      y_mag, y_clip;
    logic              y_neg;

    assign ceil_sat = (ceiling < CEIL_MIN) ? CEIL_MIN :
                      (ceiling > GAIN_ONE) ? GAIN_ONE : ceiling;
    assign atk_sat  = (attack > GAIN_ONE) ? GAIN_ONE : attack;
    assign rel_sat  = (release_c > GAIN_ONE) ? GAIN_ONE : release_c;
    assign ceil_scaled = {ceil_sat, {(S-1){1'b0}}};

    assign mag_l = in_left[S-1]  ? (~in_left + 1'b1)  : in_left;
    assign mag_r = in_right[S-1] ? (~in_right + 1'b1) : in_right;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mag_l_reg  <= mag_l;
            mag_r_reg  <= mag_r;
            neg_l_reg  <= in_left[S-1];
            neg_r_reg  <= in_right[S-1];
            stereo_reg <= stereo;
            ceil_s_reg <= ceil_scaled[CW-1:FRAC_BITS];
            low_reg    <= ceil_scaled[FRAC_BITS-1:0];
            atk_reg    <= atk_sat;
            rel_reg    <= rel_sat;
        end else if (cmd.div_step) begin
            low_reg <= {low_reg[FRAC_BITS-2:0], 1'b0};
        end
    end

    // The peak is above the ceiling exactly when it exceeds the ceiling in sample units.
    assign peak   = (stereo_reg && (mag_r_reg > mag_l_reg)) ? mag_r_reg : mag_l_reg;
    assign exceed = (peak > ceil_s_reg);

    // One restoring division step per cycle; the quotient is known to fit 23 bits.
    assign trial      = {rem_reg, low_reg[FRAC_BITS-1]};
    assign trial_ge   = (trial >= {1'b0, peak_reg});
    assign trial_diff = trial - {1'b0, peak_reg};

    always_ff @(posedge aclk) begin
        if (cmd.peak_load) begin
            peak_reg   <= peak;
            rem_reg    <= ceil_s_reg;
            needed_reg <= exceed ? '0 : GAIN_ONE;
        end else if (cmd.div_step) begin
            rem_reg    <= trial_ge ? trial_diff[S-1:0] : trial[S-1:0];
            needed_reg <= {needed_reg[GAIN_W-2:0], trial_ge};
        end
    end

    // Shared multiplier with a registered product.
    assign go_attack = (needed_reg < gain_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.gain_mul) begin
            mul_a = go_attack ? MW'(atk_reg) : MW'(rel_reg);
            mul_b = go_attack ? (gain_reg - needed_reg) : (GAIN_ONE - gain_reg);
        end else if (cmd.mul_left) begin
            mul_a = MW'(mag_l_reg);
            mul_b = gain_reg;
        end else if (cmd.mul_right) begin
            mul_a = MW'(mag_r_reg);
            mul_b = gain_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.gain_mul || cmd.mul_left || cmd.mul_right) begin
            prod_reg <= PW'(mul_a) * PW'(mul_b);
        end
        if (cmd.gain_mul) begin
            attack_reg <= go_attack;
        end
    end

    assign prod_rnd = prod_reg + RND;
    assign step_g   = prod_rnd[FRAC_BITS+GAIN_W-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_ONE;
        end else if (cmd.gain_upd) begin
            gain_reg <= attack_reg ? (gain_reg - step_g) : (gain_reg + step_g);
        end
    end

    // Rounded magnitude, clipped to the ceiling, sign restored; right is zero in mono mode.
    assign y_mag  = prod_rnd[FRAC_BITS+S-1:FRAC_BITS];
    assign y_clip = (y_mag > ceil_s_reg) ? ceil_s_reg : y_mag;
    assign y_neg  = cmd.clip_left ? neg_l_reg : neg_r_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clip_left) begin
            res_l_reg <= y_neg ? (~y_clip + 1'b1) : y_clip;
        end
        if (cmd.clip_right) begin
            res_r_reg <= !stereo_reg ? '0 : (y_neg ? (~y_clip + 1'b1) : y_clip);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_left_reg  <= res_l_reg;
            out_right_reg <= res_r_reg;
            out_gain_reg  <= gain_reg;
        end
    end

    assign stat.div_go   = exceed;
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;
    assign out_gain  = out_gain_reg;

endmodule

FILE: hdl/stereo_peak_limiter.sv
// Top level of the stereo peak limiter: register file, controller and datapath.
// Each frame passes through peak detection, the 23-step serial divider (one bit per
// cycle, only when the peak exceeds the ceiling), the gain multiply and update, both
// channel multiplies and clips, and the output register. Frames are taken one at a
// time; the shared multiplier serves the gain update and both channels in turn.
// Reset: aresetn is synchronous and active low; it restores the register defaults,
// sets the kept gain to unity and empties the output register.
module stereo_peak_limiter
    import plim_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: left_in, right_in, zero padding.
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: left_out, right_out, gain_now, zero padding.
    output logic [((2*SAMPLE_BITS+GAIN_W+7)/8)*8-1:0] m_tdata,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int S     = SAMPLE_BITS;
    localparam int OUT_W = ((2*S+GAIN_W+7)/8)*8;

    plim_cmd_t         cmd;
    plim_stat_t        stat;
    logic [GAIN_W-1:0] ceiling, attack, release_c;
    logic              stereo;
    logic [S-1:0]      out_left, out_right;
    logic [GAIN_W-1:0] out_gain;

    // Register file. Software loads the ceiling and the smoothing coefficients
    // as Q23 values; the datapath saturates them to their legal ranges.
    plim_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .ceiling   (ceiling),
        .attack    (attack),
        .release_c (release_c),
        .stereo    (stereo)
    );

    // The controller takes one frame at a time. It walks through peak detection,
    // the optional division, the gain update and the two channel multiplies, then
    // waits until the output register is free before handing over the result.
    plim_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the captured frame, the divider, one shared multiplier,
    // the kept gain and the output register.
    plim_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_left   (s_tdata[S-1:0]),
        .in_right  (s_tdata[2*S-1:S]),
        .ceiling   (ceiling),
        .attack    (attack),
        .release_c (release_c),
        .stereo    (stereo),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_left  (out_left),
        .out_right (out_right),
        .out_gain  (out_gain)
    );

    // The input is ready only while the controller is idle. Because the result
    // sits in its own register, a new transaction can be taken while the previous
    // result still waits for the downstream side.
    assign s_tready = cmd.in_ready;
    assign m_tdata  = OUT_W'({out_gain, out_right, out_left});

endmodule

FILE: hdl/plim_checker.sv
// Port-level checks for the stereo peak limiter and their bind.
module plim_checker
    import plim_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [((2*SAMPLE_BITS+GAIN_W+7)/8)*8-1:0] m_tdata
);

    localparam int GB = 2*SAMPLE_BITS;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The reported gain never exceeds unity.
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[GB+GAIN_W-1:GB] <= GAIN_ONE))
        else $error("gain above unity");

    // Frames are processed one at a time.
    a_one_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a frame is in progress");

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stereo_peak_limiter plim_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_plim_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
